FILE: rtl/mset_pkg.sv
package mset_pkg;

  localparam int OP_W      = 2;
  localparam int MASK_W    = 8;
  localparam int TIME_W    = 32;
  localparam int MAX_SLOTS = 32;
  localparam int SLOTS_DEF = 8;

  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_ENABLE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DISABLE = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch input fields, clear walk state
    logic apply;     // enable/disable update
    logic walk_rd;   // read slot memories at walk index, advance
    logic step;      // advance millisecond count
    logic out_load;  // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/mset_ctrl.sv
module mset_ctrl import mset_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_operation,
  output logic            in_ready,
  output cmd_t            cmd,
  input  sts_t            sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_operation == OP_TICK) ? S_WALK : S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.apply = 1'b1;
        state_nxt = S_FINISH;
      end
      S_WALK: begin
        cmd.walk_rd = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last slot is checked this cycle; count advances at the same edge
        cmd.step  = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/mset_dp.sv
module mset_dp import mset_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [MASK_W-1:0] in_slot_mask,
  input  logic [TIME_W-1:0] in_period_ms,
  input  logic              in_periodic,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [MASK_W-1:0] out_fired_mask,
  output logic [MASK_W-1:0] out_enabled_mask,
  output logic [TIME_W-1:0] out_time_ms
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // captured item
  logic [OP_W-1:0]   op_r;
  logic [SLOTS-1:0]  mask_r;
  logic [TIME_W-1:0] period_r;
  logic              periodic_r;

  logic [TIME_W-1:0] now_r;
  logic [SLOTS-1:0]  en_r, en_nxt;
  logic [SLOTS-1:0]  fired_r, fired_nxt;

  // slot walk: read stage then check stage
  logic [IW-1:0]     rd_idx_r;
  logic              chk_v_r;
  logic [IW-1:0]     chk_idx_r;
  logic [TIME_W-1:0] due_q_r;
  logic [TIME_W-1:0] rel_q_r;

  logic [TIME_W-1:0] due_mem [SLOTS];
  logic [TIME_W-1:0] rel_mem [SLOTS];

  logic              out_valid_r;
  logic [MASK_W-1:0] out_fired_r;
  logic [MASK_W-1:0] out_en_r;
  logic [TIME_W-1:0] out_time_r;

  logic [MAX_SLOTS-1:0] mask_ext;
  logic                 onehot;
  logic [IW-1:0]        arm_idx;
  logic                 arm_we;
  logic                 hit;
  logic                 reload_zero;

  assign mask_ext = MAX_SLOTS'(in_slot_mask);

  assign onehot = (mask_r != '0) && ((mask_r & (mask_r - SLOTS'(1))) == '0);

  always_comb begin
    arm_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (mask_r[i]) begin
        arm_idx = IW'(i);
      end
    end
  end

  assign arm_we      = cmd.apply && (op_r == OP_ENABLE) && onehot;
  assign hit         = chk_v_r && en_r[chk_idx_r] && (due_q_r == now_r);
  assign reload_zero = (rel_q_r == '0);

  always_comb begin
    en_nxt    = en_r;
    fired_nxt = fired_r;
    if (cmd.apply) begin
      case (op_r)
        OP_ENABLE:  en_nxt = en_r | mask_r;
        OP_DISABLE: en_nxt = en_r & ~mask_r;
        default:    en_nxt = en_r;
      endcase
    end
    if (hit) begin
      fired_nxt[chk_idx_r] = 1'b1;
      if (reload_zero) begin
        en_nxt[chk_idx_r] = 1'b0;
      end
    end
    if (cmd.capture) begin
      fired_nxt = '0;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_operation;
      mask_r     <= mask_ext[SLOTS-1:0];
      period_r   <= in_period_ms;
      periodic_r <= in_periodic;
    end
  end

  // slot memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (arm_we) begin
      due_mem[arm_idx] <= now_r + period_r;
      rel_mem[arm_idx] <= periodic_r ? period_r : '0;
    end else if (hit && !reload_zero) begin
      due_mem[chk_idx_r] <= due_q_r + rel_q_r;
    end
    if (cmd.walk_rd) begin
      due_q_r <= due_mem[rd_idx_r];
      rel_q_r <= rel_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r    <= '0;
      en_r     <= '0;
      fired_r  <= '0;
      rd_idx_r <= '0;
      chk_v_r  <= 1'b0;
      chk_idx_r <= '0;
    end else begin
      en_r      <= en_nxt;
      fired_r   <= fired_nxt;
      chk_v_r   <= cmd.walk_rd;
      chk_idx_r <= rd_idx_r;
      if (cmd.capture) begin
        rd_idx_r <= '0;
      end else if (cmd.walk_rd) begin
        rd_idx_r <= rd_idx_r + IW'(1);
      end
      if (cmd.step) begin
        now_r <= now_r + TIME_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_fired_r <= MASK_W'(fired_r);
      out_en_r    <= MASK_W'(en_r);
      out_time_r  <= now_r;
    end
  end

  assign sts.walk_last = (rd_idx_r == IW'(SLOTS - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_fired_mask   = out_fired_r;
  assign out_enabled_mask = out_en_r;
  assign out_time_ms      = out_time_r;

endmodule

FILE: rtl/multi_slot_millisecond_event_timer_top.sv
// Flow: a tick walks every slot through the due/reload memories on their
//   single read port, then passes a drain state and a finish state; enable,
//   disable and unused codes pass an exec state and the finish state.
// A new item is taken only once the last result is loaded (in_ready in idle).
// Reset (rst_n, synchronous, active low) clears the count, enables and
//   handshakes; slot memories are not cleared and hold data only once armed.
module multi_slot_millisecond_event_timer_top import mset_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [MASK_W-1:0] in_slot_mask,
  input  logic [TIME_W-1:0] in_period_ms,
  input  logic              in_periodic,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MASK_W-1:0] out_fired_mask,
  output logic [MASK_W-1:0] out_enabled_mask,
  output logic [TIME_W-1:0] out_time_ms
);

  cmd_t cmd;
  sts_t sts;

  mset_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  mset_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_operation),
    .in_slot_mask     (in_slot_mask),
    .in_period_ms     (in_period_ms),
    .in_periodic      (in_periodic),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_fired_mask   (out_fired_mask),
    .out_enabled_mask (out_enabled_mask),
    .out_time_ms      (out_time_ms)
  );

endmodule

FILE: rtl/mset_checker.sv
module mset_checker import mset_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [MASK_W-1:0] out_fired_mask,
  input logic [MASK_W-1:0] out_enabled_mask,
  input logic [TIME_W-1:0] out_time_ms
);

  logic [MASK_W-1:0] last_en_r;
  logic [TIME_W-1:0] last_time_r;

  // state as shown by the last result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_en_r   <= '0;
      last_time_r <= '0;
    end else if (out_valid && out_ready) begin
      last_en_r   <= out_enabled_mask;
      last_time_r <= out_time_ms;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fired_mask)
      && $stable(out_enabled_mask) && $stable(out_time_ms))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_fire_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fired_mask & ~last_en_r) == '0)
    else $error("slot fired that was not enabled");

  a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_time_ms == last_time_r) ||
                  (out_time_ms == last_time_r + TIME_W'(1)))
    else $error("millisecond count jumped");

endmodule

bind multi_slot_millisecond_event_timer_top mset_checker u_mset_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_fired_mask   (out_fired_mask),
  .out_enabled_mask (out_enabled_mask),
  .out_time_ms      (out_time_ms)
);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb import mset_pkg::*;;

  localparam int SLOTS = SLOTS_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int N_DIRECTED = 25;
  localparam int N_RANDOM = 1900;
  localparam int DRAIN_CYCLES = 2 * (SLOTS + 2);

  typedef struct packed {
    logic [MASK_W-1:0] fired;
    logic [MASK_W-1:0] enabled;
    logic [TIME_W-1:0] time_ms;
  } timer_report_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [MASK_W-1:0] mask;
    logic [TIME_W-1:0] period;
    logic              periodic;
    logic              known;
    timer_report_t     want;
  } timer_cmd_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation = OP_TICK;
  logic [MASK_W-1:0] in_slot_mask = '0;
  logic [TIME_W-1:0] in_period_ms = '0;
  logic              in_periodic = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MASK_W-1:0] out_fired_mask;
  logic [MASK_W-1:0] out_enabled_mask;
  logic [TIME_W-1:0] out_time_ms;

  // shadow of the timer state
  logic [TIME_W-1:0] clock_ms = '0;
  logic [SLOTS-1:0]  live_slots = '0;
  logic [SLOTS-1:0]  armed_slots = '0;
  logic [TIME_W-1:0] due_at [SLOTS];
  logic [TIME_W-1:0] reload_by [SLOTS];

  timer_report_t pending_reports [$];
  int errors = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_run = 0;

  multi_slot_millisecond_event_timer_top #(.SLOTS(SLOTS)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_slot_mask     (in_slot_mask),
    .in_period_ms     (in_period_ms),
    .in_periodic      (in_periodic),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_fired_mask   (out_fired_mask),
    .out_enabled_mask (out_enabled_mask),
    .out_time_ms      (out_time_ms)
  );

  always #2 clk = ~clk;

  // after reset, arm every slot, and exercise zero periods, wrap of the
  // due time, non-one-hot enables and the unused code
  timer_cmd_t dir_rows [N_DIRECTED] = '{
    '{OP_TICK,    8'h00, 32'h0000_0000, 1'b0, 1'b1, '{8'h00, 8'h00, 32'd1}},
    '{OP_UNUSED,  8'hff, 32'hffff_ffff, 1'b1, 1'b1, '{8'h00, 8'h00, 32'd1}},
    '{OP_DISABLE, 8'hff, 32'h0000_0000, 1'b0, 1'b1, '{8'h00, 8'h00, 32'd1}},
    '{OP_ENABLE,  8'h01, 32'h0000_0000, 1'b1, 1'b1, '{8'h00, 8'h01, 32'd1}},
    '{OP_TICK,    8'h00, 32'h0000_0000, 1'b0, 1'b1, '{8'h01, 8'h00, 32'd2}},
    '{OP_ENABLE,  8'h80, 32'hffff_ffff, 1'b1, 1'b1, '{8'h00, 8'h80, 32'd2}},
    '{OP_ENABLE,  8'h02, 32'h0000_0001, 1'b1, 1'b1, '{8'h00, 8'h82, 32'd2}},
    '{OP_ENABLE,  8'h04, 32'h0000_0002, 1'b0, 1'b1, '{8'h00, 8'h86, 32'd2}},
    '{OP_ENABLE,  8'h08, 32'h0000_0003, 1'b1, 1'b1, '{8'h00, 8'h8e, 32'd2}},
    '{OP_ENABLE,  8'h10, 32'h0000_0000, 1'b0, 1'b1, '{8'h00, 8'h9e, 32'd2}},
    '{OP_ENABLE,  8'h20, 32'h0000_0005, 1'b1, 1'b1, '{8'h00, 8'hbe, 32'd2}},
    '{OP_ENABLE,  8'h40, 32'h8000_0000, 1'b0, 1'b1, '{8'h00, 8'hfe, 32'd2}},
    '{OP_ENABLE,  8'h01, 32'h7fff_ffff, 1'b1, 1'b1, '{8'h00, 8'hff, 32'd2}},
    '{OP_TICK,    8'h00, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{OP_DISABLE, 8'h55, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{OP_ENABLE,  8'hff, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{OP_TICK,    8'h00, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{OP_TICK,    8'h00, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{OP_ENABLE,  8'h00, 32'haaaa_aaaa, 1'b1, 1'b0, '0},
    '{OP_DISABLE, 8'h00, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{OP_TICK,    8'h00, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{OP_ENABLE,  8'h04, 32'h0000_0000, 1'b1, 1'b0, '0},
    '{OP_TICK,    8'h00, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{OP_UNUSED,  8'h00, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{OP_DISABLE, 8'hff, 32'h0000_0000, 1'b0, 1'b0, '0}
  };

  function automatic timer_report_t advance_timer(
    input logic [OP_W-1:0] op, input logic [MASK_W-1:0] mask,
    input logic [TIME_W-1:0] period, input logic periodic
  );
    timer_report_t r;
    r = '0;
    case (op)
      OP_ENABLE: begin
        live_slots |= mask[SLOTS-1:0];
        if ($onehot(mask)) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (mask[s]) begin
              due_at[s] = clock_ms + period;
              reload_by[s] = periodic ? period : '0;
              armed_slots[s] = 1'b1;
            end
          end
        end
      end
      OP_DISABLE: live_slots &= ~mask[SLOTS-1:0];
      OP_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (live_slots[s] && due_at[s] == clock_ms) begin
            r.fired[s] = 1'b1;
            if (reload_by[s] != '0) due_at[s] += reload_by[s];
            else live_slots[s] = 1'b0;
          end
        end
        clock_ms += 1;
      end
      default: ;
    endcase
    r.enabled = live_slots;
    r.time_ms = clock_ms;
    return r;
  endfunction

  task automatic send_item(input timer_cmd_t cmd);
    timer_report_t rep;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_operation <= cmd.op;
    in_slot_mask <= cmd.mask;
    in_period_ms <= cmd.period;
    in_periodic  <= cmd.periodic;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    rep = advance_timer(cmd.op, cmd.mask, cmd.period, cmd.periodic);
    pending_reports.push_back(cmd.known ? cmd.want : rep);
  endtask

  function automatic timer_cmd_t random_cmd();
    timer_cmd_t c;
    int pick;
    c = '0;
    c.periodic = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      c.op = OP_TICK;
      c.mask = 8'($urandom_range(0, 255));
      c.period = $urandom();
    end else if (pick < 80) begin
      c.op = OP_ENABLE;
      pick = $urandom_range(0, 9);
      if (pick < 7) c.period = $urandom_range(0, 12);
      else if (pick == 7) c.period = $urandom_range(13, 200);
      else c.period = $urandom();
      // a wide mask may only name slots that already hold a due time
      if ($urandom_range(0, 9) < 7) c.mask = 8'h01 << $urandom_range(0, SLOTS - 1);
      else c.mask = 8'($urandom_range(0, 255)) & MASK_W'(armed_slots);
    end else if (pick < 95) begin
      c.op = OP_DISABLE;
      c.mask = 8'($urandom_range(0, 255)) & 8'($urandom_range(0, 255));
      c.period = $urandom();
    end else begin
      c.op = OP_UNUSED;
      c.mask = 8'($urandom_range(0, 255));
      c.period = $urandom();
    end
    return c;
  endfunction

  // receiver: runs of always-ready, random ready and heavy stall
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run = $urandom_range(16, 80);
    end
    stall_run--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_reports
    timer_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer: fired %h enabled %h time %h", $time,
                 out_fired_mask, out_enabled_mask, out_time_ms);
      end else begin
        want = pending_reports.pop_front();
        check_field("fired_mask", 32'(want.fired), 32'(out_fired_mask));
        check_field("enabled_mask", 32'(want.enabled), 32'(out_enabled_mask));
        check_field("time_ms", want.time_ms, out_time_ms);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[k]) send_item(dir_rows[k]);
    for (int n = 0; n < N_RANDOM; n++) send_item(random_cmd());
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // well above the slowest legal run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/mset_pkg.sv
rtl/mset_ctrl.sv
rtl/mset_dp.sv
rtl/multi_slot_millisecond_event_timer_top.sv
rtl/mset_checker.sv
test/tb.sv
